@@ sv/luds_pkg.sv @@
// Shared types, constants and codes of the LU decompose and solve unit.
package luds_pkg;

  localparam int MAX_DIM_DEF   = 16;
  localparam int FRAC_BITS_DEF = 16;

  localparam int DATA_W  = 32;
  localparam int INDEX_W = 4;
  localparam int DIM_W   = 5;
  localparam int THR_W   = 31;

  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;
  localparam logic [THR_W-1:0] THR_RESET = 31'd1;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  localparam logic OP_MATRIX = 1'b0;
  localparam logic OP_RHS    = 1'b1;

  localparam logic REG_DIMENSION = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SINGULAR = 2'd1;
  localparam logic [1:0] STATUS_SOLUTION = 2'd2;
  localparam logic [1:0] STATUS_REFUSED  = 2'd3;

  typedef struct packed {
    logic valid;
    logic neg;
    logic zdiv;
    logic aneg;
  } luds_div_flags_t;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_F_INIT,
    ST_F_PIV,
    ST_F_PIV_CHK,
    ST_F_PIV_END,
    ST_F_SW_A,
    ST_F_SW_B,
    ST_F_SW_C,
    ST_F_SW_D,
    ST_F_PS_A,
    ST_F_PS_B,
    ST_F_PS_C,
    ST_F_PS_D,
    ST_F_PV_RD,
    ST_F_PV_LD,
    ST_F_ROW,
    ST_F_DIV_ST,
    ST_F_DIV_W,
    ST_F_UPD_RD,
    ST_F_UPD_RB,
    ST_F_UPD_WB,
    ST_S_RES,
    ST_S_PERM_A,
    ST_S_PERM_B,
    ST_S_PERM_C,
    ST_S_FW_I,
    ST_S_FW_L,
    ST_S_FW_K,
    ST_S_MAC_M,
    ST_S_MAC_S,
    ST_S_BK_I,
    ST_S_BK_L,
    ST_S_BK_K,
    ST_S_BK_DS,
    ST_S_BK_DW,
    ST_S_EM_RD,
    ST_S_EM_W
  } luds_state_e;

endpackage

@@ sv/luds_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module luds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ sv/luds_div_cell.sv @@
// One restoring division step cell of the divider chain.
module luds_div_cell #(
  parameter int NW = 48
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  luds_pkg::luds_div_flags_t flags_i,
  input  logic [32+NW-1:0]          acc_i,
  input  logic [31:0]               dvs_i,
  output luds_pkg::luds_div_flags_t flags_o,
  output logic [32+NW-1:0]          acc_o,
  output logic [31:0]               dvs_o
);

  localparam int AW = 32 + NW;

  logic [32:0]   hi;
  logic          ge;
  logic [32:0]   rem;
  logic [AW-1:0] acc_d;

  always_comb begin
    hi    = acc_i[AW-1:NW-1];
    ge    = (hi >= {1'b0, dvs_i});
    rem   = ge ? (hi - {1'b0, dvs_i}) : hi;
    acc_d = {rem[31:0], acc_i[NW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_o <= '0;
    end else begin
      flags_o <= flags_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_o <= acc_d;
    dvs_o <= dvs_i;
  end

endmodule

@@ sv/luds_div_chain.sv @@
// Saturating fixed-point divider built as a chain of restoring step cells.
module luds_div_chain #(
  parameter int FRAC_BITS = luds_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic               done_o,
  output logic signed [31:0] q_o,
  output logic               ovf_o
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int AW = 32 + NW;

  luds_pkg::luds_div_flags_t flags [NW+1];
  logic [AW-1:0]             acc   [NW+1];
  logic [31:0]               dvs   [NW+1];

  logic [31:0]   a_mag;
  logic [31:0]   b_mag;
  logic [NW-1:0] uq;
  logic          pos_big;
  logic          neg_big;

  always_comb begin
    a_mag = a_i[31] ? (32'd0 - a_i) : a_i;
    b_mag = b_i[31] ? (32'd0 - b_i) : b_i;
    flags[0].valid = start_i;
    flags[0].neg   = a_i[31] ^ b_i[31];
    flags[0].zdiv  = (b_i == 32'sd0);
    flags[0].aneg  = a_i[31];
    acc[0] = {32'd0, a_mag, {FRAC_BITS{1'b0}}};
    dvs[0] = b_mag;
  end

  for (genvar g = 0; g < NW; g++) begin : g_cell
    luds_div_cell #(.NW(NW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .flags_i (flags[g]),
      .acc_i   (acc[g]),
      .dvs_i   (dvs[g]),
      .flags_o (flags[g+1]),
      .acc_o   (acc[g+1]),
      .dvs_o   (dvs[g+1])
    );
  end

  always_comb begin
    uq      = acc[NW][NW-1:0];
    pos_big = |uq[NW-1:31];
    neg_big = (|uq[NW-1:32]) || (uq[31] && (|uq[30:0]));
    done_o  = flags[NW].valid;
    ovf_o   = 1'b0;
    if (flags[NW].zdiv) begin
      q_o   = flags[NW].aneg ? luds_pkg::S32_MIN : luds_pkg::S32_MAX;
      ovf_o = 1'b1;
    end else if (flags[NW].neg) begin
      if (neg_big) begin
        q_o   = luds_pkg::S32_MIN;
        ovf_o = 1'b1;
      end else begin
        q_o = 32'd0 - uq[31:0];
      end
    end else if (pos_big) begin
      q_o   = luds_pkg::S32_MAX;
      ovf_o = 1'b1;
    end else begin
      q_o = uq[31:0];
    end
  end

endmodule

@@ sv/lu_decompose_solve_unit.sv @@
// Top level of the LU decompose and solve unit: sequencer, stores and config port.
// Matrix and right-hand-side elements are taken one per cycle while the unit is idle;
// the m*m-th matrix element starts an in-place LU factorization with partial pivoting
// and the m-th right-hand-side element starts a solve. Every factor and solve step is
// run by one sequencer over a simple dual-port matrix RAM: a pivot search per column,
// a row swap where the pivot row differs, a divider-chain quotient per multiplier and
// a saturating multiply-subtract per updated element; a solve permutes the right-hand
// side, runs forward and back substitution and emits the solution in index order. Results
// leave through an output register, so a new element is taken while the last result
// still waits.
module lu_decompose_solve_unit #(
  parameter int MAX_DIM   = luds_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = luds_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [31:0] element_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_value_o,
  output logic [3:0]  result_index_o,
  output logic [1:0]  status_o,
  output logic        overflow_o,
  output logic        last_of_run_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CW     = $clog2(MAX_DIM + 1);
  localparam int MDEPTH = 1 << (2 * IW);

  luds_pkg::luds_state_e state_q, state_d;

  logic [4:0]  dim_q, dim_d;
  logic [30:0] thr_q, thr_d;
  logic        factor_valid_q, factor_valid_d;
  logic [CW-1:0] ld_row_q, ld_row_d, ld_col_q, ld_col_d;
  logic [CW-1:0] rhs_cnt_q, rhs_cnt_d;
  logic [CW-1:0] col_q, col_d, rr_q, rr_d, cc_q, cc_d, best_q, best_d;
  logic [CW-1:0] i_q, i_d, k_q, k_d;
  logic [31:0] bestv_q, bestv_d;
  logic signed [31:0] piv_q, piv_d, f_q, f_d, tmp_q, tmp_d, acc_q, acc_d;
  logic [IW-1:0] ptmp_q, ptmp_d;
  logic        bk_q, bk_d;
  logic        run_ovf_q, run_ovf_d;
  logic [1:0]  res_status_q, res_status_d;
  logic signed [63:0] prod_q, prod_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_value_q, out_value_d;
  logic [3:0]  out_index_q, out_index_d;
  logic [1:0]  out_status_q, out_status_d;
  logic        out_ovf_q, out_ovf_d;
  logic        out_last_q, out_last_d;

  logic [CW-1:0] m_eff;
  logic          accept;
  logic          cfg_we;
  logic          out_free;

  logic                 m_we;
  logic [2*IW-1:0]      m_waddr, m_raddr;
  logic signed [31:0]   m_wdata, m_rdata;
  logic                 p_we;
  logic [IW-1:0]        p_waddr, p_raddr, p_wdata, p_rdata;
  logic                 r_we;
  logic [IW-1:0]        r_waddr, r_raddr;
  logic [31:0]          r_wdata, r_rdata;
  logic                 y_we;
  logic [IW-1:0]        y_waddr, y_raddr;
  logic signed [31:0]   y_wdata, y_rdata;

  logic signed [31:0] mul_a, mul_b, mac_acc;
  logic signed [63:0] diff;
  logic               sat_ovf;
  logic signed [31:0] sat_val;
  logic [31:0]        piv_mag;

  logic               div_start, div_done, div_ovf;
  logic signed [31:0] div_a, div_b, div_q;

  luds_ram #(.WIDTH(32), .DEPTH(MDEPTH)) u_mat_ram (
    .clk_i (clk_i), .we_i (m_we), .waddr_i (m_waddr), .wdata_i (m_wdata),
    .raddr_i (m_raddr), .rdata_o (m_rdata)
  );

  luds_ram #(.WIDTH(IW), .DEPTH(MAX_DIM)) u_perm_ram (
    .clk_i (clk_i), .we_i (p_we), .waddr_i (p_waddr), .wdata_i (p_wdata),
    .raddr_i (p_raddr), .rdata_o (p_rdata)
  );

  luds_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_rhs_ram (
    .clk_i (clk_i), .we_i (r_we), .waddr_i (r_waddr), .wdata_i (r_wdata),
    .raddr_i (r_raddr), .rdata_o (r_rdata)
  );

  luds_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_y_ram (
    .clk_i (clk_i), .we_i (y_we), .waddr_i (y_waddr), .wdata_i (y_wdata),
    .raddr_i (y_raddr), .rdata_o (y_rdata)
  );

  luds_div_chain #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start),
    .a_i (div_a), .b_i (div_b), .done_o (div_done), .q_o (div_q), .ovf_o (div_ovf)
  );

  always_comb begin
    if (dim_q == 5'd0) begin
      m_eff = CW'(1);
    end else if ({27'd0, dim_q} > 32'(MAX_DIM)) begin
      m_eff = CW'(MAX_DIM);
    end else begin
      m_eff = CW'(dim_q);
    end
  end

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != luds_pkg::ST_IDLE);
  assign cfg_we     = psel && penable && pwrite;
  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == luds_pkg::REG_DIMENSION) ? {27'd0, dim_q} : {1'b0, thr_q};
  assign out_free   = !out_valid_q || !out_stall_i;

  assign mul_a   = (state_q == luds_pkg::ST_S_MAC_M) ? m_rdata : f_q;
  assign mul_b   = (state_q == luds_pkg::ST_S_MAC_M) ? y_rdata : m_rdata;
  assign prod_d  = 64'(mul_a) * 64'(mul_b);
  assign mac_acc = (state_q == luds_pkg::ST_F_UPD_WB) ? m_rdata : acc_q;
  assign diff    = 64'(mac_acc) - (prod_q >>> FRAC_BITS);
  assign sat_ovf = !((&diff[63:31]) || !(|diff[63:31]));
  assign sat_val = sat_ovf ? (diff[63] ? luds_pkg::S32_MIN : luds_pkg::S32_MAX) : diff[31:0];
  assign piv_mag = m_rdata[31] ? (32'd0 - m_rdata) : m_rdata;

  assign div_a = (state_q == luds_pkg::ST_F_DIV_ST) ? m_rdata : acc_q;
  assign div_b = (state_q == luds_pkg::ST_F_DIV_ST) ? piv_q : m_rdata;

  always_comb begin
    state_d        = state_q;
    dim_d          = dim_q;
    thr_d          = thr_q;
    factor_valid_d = factor_valid_q;
    ld_row_d       = ld_row_q;
    ld_col_d       = ld_col_q;
    rhs_cnt_d      = rhs_cnt_q;
    col_d          = col_q;
    rr_d           = rr_q;
    cc_d           = cc_q;
    best_d         = best_q;
    i_d            = i_q;
    k_d            = k_q;
    bestv_d        = bestv_q;
    piv_d          = piv_q;
    f_d            = f_q;
    tmp_d          = tmp_q;
    acc_d          = acc_q;
    ptmp_d         = ptmp_q;
    bk_d           = bk_q;
    run_ovf_d      = run_ovf_q;
    res_status_d   = res_status_q;

    out_valid_d  = out_valid_q && out_stall_i;
    out_value_d  = out_value_q;
    out_index_d  = out_index_q;
    out_status_d = out_status_q;
    out_ovf_d    = out_ovf_q;
    out_last_d   = out_last_q;

    m_we    = 1'b0;
    m_waddr = {rr_q[IW-1:0], col_q[IW-1:0]};
    m_wdata = sat_val;
    m_raddr = {rr_q[IW-1:0], col_q[IW-1:0]};
    p_we    = 1'b0;
    p_waddr = col_q[IW-1:0];
    p_wdata = i_q[IW-1:0];
    p_raddr = col_q[IW-1:0];
    r_we    = 1'b0;
    r_waddr = rhs_cnt_q[IW-1:0];
    r_wdata = element_value_i;
    r_raddr = p_rdata;
    y_we    = 1'b0;
    y_waddr = i_q[IW-1:0];
    y_wdata = acc_q;
    y_raddr = i_q[IW-1:0];
    div_start = 1'b0;

    case (state_q)
      luds_pkg::ST_IDLE: begin
        if (accept) begin
          if (opcode_i == luds_pkg::OP_MATRIX) begin
            factor_valid_d = 1'b0;
            m_we    = 1'b1;
            m_waddr = {ld_row_q[IW-1:0], ld_col_q[IW-1:0]};
            m_wdata = element_value_i;
            if (ld_col_q + 1'b1 == m_eff) begin
              ld_col_d = '0;
              if (ld_row_q + 1'b1 == m_eff) begin
                ld_row_d  = '0;
                run_ovf_d = 1'b0;
                i_d       = '0;
                state_d   = luds_pkg::ST_F_INIT;
              end else begin
                ld_row_d = ld_row_q + 1'b1;
              end
            end else begin
              ld_col_d = ld_col_q + 1'b1;
            end
          end else if (!factor_valid_q) begin
            rhs_cnt_d    = '0;
            res_status_d = luds_pkg::STATUS_REFUSED;
            run_ovf_d    = 1'b0;
            state_d      = luds_pkg::ST_S_RES;
          end else begin
            r_we = 1'b1;
            if (rhs_cnt_q + 1'b1 == m_eff) begin
              rhs_cnt_d = '0;
              run_ovf_d = 1'b0;
              i_d       = '0;
              state_d   = luds_pkg::ST_S_PERM_A;
            end else begin
              rhs_cnt_d = rhs_cnt_q + 1'b1;
            end
          end
        end
      end

      luds_pkg::ST_F_INIT: begin
        p_we    = 1'b1;
        p_waddr = i_q[IW-1:0];
        if (i_q + 1'b1 == m_eff) begin
          col_d   = '0;
          rr_d    = '0;
          state_d = luds_pkg::ST_F_PIV;
        end else begin
          i_d = i_q + 1'b1;
        end
      end

      luds_pkg::ST_F_PIV: begin
        state_d = luds_pkg::ST_F_PIV_CHK;
      end

      luds_pkg::ST_F_PIV_CHK: begin
        if ((rr_q == col_q) || (piv_mag > bestv_q)) begin
          bestv_d = piv_mag;
          best_d  = rr_q;
        end
        if (rr_q + 1'b1 < m_eff) begin
          rr_d    = rr_q + 1'b1;
          state_d = luds_pkg::ST_F_PIV;
        end else begin
          state_d = luds_pkg::ST_F_PIV_END;
        end
      end

      luds_pkg::ST_F_PIV_END: begin
        if ((bestv_q == 32'd0) || (bestv_q < {1'b0, thr_q})) begin
          res_status_d = luds_pkg::STATUS_SINGULAR;
          state_d      = luds_pkg::ST_S_RES;
        end else if (best_q != col_q) begin
          cc_d    = '0;
          state_d = luds_pkg::ST_F_SW_A;
        end else begin
          state_d = luds_pkg::ST_F_PV_RD;
        end
      end

      luds_pkg::ST_F_SW_A: begin
        m_raddr = {col_q[IW-1:0], cc_q[IW-1:0]};
        state_d = luds_pkg::ST_F_SW_B;
      end

      luds_pkg::ST_F_SW_B: begin
        tmp_d   = m_rdata;
        m_raddr = {best_q[IW-1:0], cc_q[IW-1:0]};
        state_d = luds_pkg::ST_F_SW_C;
      end

      luds_pkg::ST_F_SW_C: begin
        m_we    = 1'b1;
        m_waddr = {col_q[IW-1:0], cc_q[IW-1:0]};
        m_wdata = m_rdata;
        state_d = luds_pkg::ST_F_SW_D;
      end

      luds_pkg::ST_F_SW_D: begin
        m_we    = 1'b1;
        m_waddr = {best_q[IW-1:0], cc_q[IW-1:0]};
        m_wdata = tmp_q;
        if (cc_q + 1'b1 == m_eff) begin
          state_d = luds_pkg::ST_F_PS_A;
        end else begin
          cc_d    = cc_q + 1'b1;
          state_d = luds_pkg::ST_F_SW_A;
        end
      end

      luds_pkg::ST_F_PS_A: begin
        state_d = luds_pkg::ST_F_PS_B;
      end

      luds_pkg::ST_F_PS_B: begin
        ptmp_d  = p_rdata;
        p_raddr = best_q[IW-1:0];
        state_d = luds_pkg::ST_F_PS_C;
      end

      luds_pkg::ST_F_PS_C: begin
        p_we    = 1'b1;
        p_wdata = p_rdata;
        state_d = luds_pkg::ST_F_PS_D;
      end

      luds_pkg::ST_F_PS_D: begin
        p_we    = 1'b1;
        p_waddr = best_q[IW-1:0];
        p_wdata = ptmp_q;
        state_d = luds_pkg::ST_F_PV_RD;
      end

      luds_pkg::ST_F_PV_RD: begin
        m_raddr = {col_q[IW-1:0], col_q[IW-1:0]};
        state_d = luds_pkg::ST_F_PV_LD;
      end

      luds_pkg::ST_F_PV_LD: begin
        piv_d   = m_rdata;
        rr_d    = col_q + 1'b1;
        state_d = luds_pkg::ST_F_ROW;
      end

      luds_pkg::ST_F_ROW: begin
        if (rr_q >= m_eff) begin
          if (col_q + 1'b1 >= m_eff) begin
            factor_valid_d = 1'b1;
            res_status_d   = luds_pkg::STATUS_OK;
            state_d        = luds_pkg::ST_S_RES;
          end else begin
            col_d   = col_q + 1'b1;
            rr_d    = col_q + 1'b1;
            state_d = luds_pkg::ST_F_PIV;
          end
        end else begin
          state_d = luds_pkg::ST_F_DIV_ST;
        end
      end

      luds_pkg::ST_F_DIV_ST: begin
        div_start = 1'b1;
        state_d   = luds_pkg::ST_F_DIV_W;
      end

      luds_pkg::ST_F_DIV_W: begin
        if (div_done) begin
          f_d       = div_q;
          run_ovf_d = run_ovf_q | div_ovf;
          m_we      = 1'b1;
          m_wdata   = div_q;
          cc_d      = col_q + 1'b1;
          state_d   = luds_pkg::ST_F_UPD_RD;
        end
      end

      luds_pkg::ST_F_UPD_RD: begin
        if (cc_q >= m_eff) begin
          rr_d    = rr_q + 1'b1;
          state_d = luds_pkg::ST_F_ROW;
        end else begin
          m_raddr = {col_q[IW-1:0], cc_q[IW-1:0]};
          state_d = luds_pkg::ST_F_UPD_RB;
        end
      end

      luds_pkg::ST_F_UPD_RB: begin
        m_raddr = {rr_q[IW-1:0], cc_q[IW-1:0]};
        state_d = luds_pkg::ST_F_UPD_WB;
      end

      luds_pkg::ST_F_UPD_WB: begin
        m_we      = 1'b1;
        m_waddr   = {rr_q[IW-1:0], cc_q[IW-1:0]};
        run_ovf_d = run_ovf_q | sat_ovf;
        cc_d      = cc_q + 1'b1;
        state_d   = luds_pkg::ST_F_UPD_RD;
      end

      luds_pkg::ST_S_RES: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = '0;
          out_index_d  = '0;
          out_status_d = res_status_q;
          out_ovf_d    = run_ovf_q;
          out_last_d   = 1'b1;
          state_d      = luds_pkg::ST_IDLE;
        end
      end

      luds_pkg::ST_S_PERM_A: begin
        p_raddr = i_q[IW-1:0];
        state_d = luds_pkg::ST_S_PERM_B;
      end

      luds_pkg::ST_S_PERM_B: begin
        state_d = luds_pkg::ST_S_PERM_C;
      end

      luds_pkg::ST_S_PERM_C: begin
        y_we    = 1'b1;
        y_wdata = r_rdata;
        if (i_q + 1'b1 == m_eff) begin
          i_d     = '0;
          state_d = luds_pkg::ST_S_FW_I;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = luds_pkg::ST_S_PERM_A;
        end
      end

      luds_pkg::ST_S_FW_I: begin
        if (i_q >= m_eff) begin
          i_d     = m_eff - 1'b1;
          state_d = luds_pkg::ST_S_BK_I;
        end else begin
          state_d = luds_pkg::ST_S_FW_L;
        end
      end

      luds_pkg::ST_S_FW_L: begin
        acc_d   = y_rdata;
        k_d     = '0;
        bk_d    = 1'b0;
        state_d = luds_pkg::ST_S_FW_K;
      end

      luds_pkg::ST_S_FW_K: begin
        if (k_q >= i_q) begin
          y_we    = 1'b1;
          i_d     = i_q + 1'b1;
          state_d = luds_pkg::ST_S_FW_I;
        end else begin
          m_raddr = {i_q[IW-1:0], k_q[IW-1:0]};
          y_raddr = k_q[IW-1:0];
          state_d = luds_pkg::ST_S_MAC_M;
        end
      end

      luds_pkg::ST_S_MAC_M: begin
        state_d = luds_pkg::ST_S_MAC_S;
      end

      luds_pkg::ST_S_MAC_S: begin
        acc_d     = sat_val;
        run_ovf_d = run_ovf_q | sat_ovf;
        k_d       = k_q + 1'b1;
        state_d   = bk_q ? luds_pkg::ST_S_BK_K : luds_pkg::ST_S_FW_K;
      end

      luds_pkg::ST_S_BK_I: begin
        state_d = luds_pkg::ST_S_BK_L;
      end

      luds_pkg::ST_S_BK_L: begin
        acc_d   = y_rdata;
        k_d     = i_q + 1'b1;
        bk_d    = 1'b1;
        state_d = luds_pkg::ST_S_BK_K;
      end

      luds_pkg::ST_S_BK_K: begin
        if (k_q >= m_eff) begin
          m_raddr = {i_q[IW-1:0], i_q[IW-1:0]};
          state_d = luds_pkg::ST_S_BK_DS;
        end else begin
          m_raddr = {i_q[IW-1:0], k_q[IW-1:0]};
          y_raddr = k_q[IW-1:0];
          state_d = luds_pkg::ST_S_MAC_M;
        end
      end

      luds_pkg::ST_S_BK_DS: begin
        div_start = 1'b1;
        state_d   = luds_pkg::ST_S_BK_DW;
      end

      luds_pkg::ST_S_BK_DW: begin
        if (div_done) begin
          y_we      = 1'b1;
          y_wdata   = div_q;
          run_ovf_d = run_ovf_q | div_ovf;
          if (i_q == '0) begin
            state_d = luds_pkg::ST_S_EM_RD;
          end else begin
            i_d     = i_q - 1'b1;
            state_d = luds_pkg::ST_S_BK_I;
          end
        end
      end

      luds_pkg::ST_S_EM_RD: begin
        state_d = luds_pkg::ST_S_EM_W;
      end

      luds_pkg::ST_S_EM_W: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = y_rdata;
          out_index_d  = 4'(i_q);
          out_status_d = luds_pkg::STATUS_SOLUTION;
          out_ovf_d    = run_ovf_q;
          out_last_d   = (i_q + 1'b1 == m_eff);
          if (i_q + 1'b1 == m_eff) begin
            state_d = luds_pkg::ST_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = luds_pkg::ST_S_EM_RD;
          end
        end
      end

      default: begin
        state_d = luds_pkg::ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      if (paddr[2] == luds_pkg::REG_DIMENSION) begin
        dim_d          = pwdata[4:0];
        ld_row_d       = '0;
        ld_col_d       = '0;
        rhs_cnt_d      = '0;
        factor_valid_d = 1'b0;
      end else begin
        thr_d = pwdata[30:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= luds_pkg::ST_IDLE;
      dim_q          <= luds_pkg::DIM_RESET;
      thr_q          <= luds_pkg::THR_RESET;
      factor_valid_q <= 1'b0;
      ld_row_q       <= '0;
      ld_col_q       <= '0;
      rhs_cnt_q      <= '0;
      col_q          <= '0;
      rr_q           <= '0;
      cc_q           <= '0;
      best_q         <= '0;
      i_q            <= '0;
      k_q            <= '0;
      bk_q           <= 1'b0;
      run_ovf_q      <= 1'b0;
      res_status_q   <= luds_pkg::STATUS_OK;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      dim_q          <= dim_d;
      thr_q          <= thr_d;
      factor_valid_q <= factor_valid_d;
      ld_row_q       <= ld_row_d;
      ld_col_q       <= ld_col_d;
      rhs_cnt_q      <= rhs_cnt_d;
      col_q          <= col_d;
      rr_q           <= rr_d;
      cc_q           <= cc_d;
      best_q         <= best_d;
      i_q            <= i_d;
      k_q            <= k_d;
      bk_q           <= bk_d;
      run_ovf_q      <= run_ovf_d;
      res_status_q   <= res_status_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bestv_q      <= bestv_d;
    piv_q        <= piv_d;
    f_q          <= f_d;
    tmp_q        <= tmp_d;
    acc_q        <= acc_d;
    ptmp_q       <= ptmp_d;
    prod_q       <= prod_d;
    out_value_q  <= out_value_d;
    out_index_q  <= out_index_d;
    out_status_q <= out_status_d;
    out_ovf_q    <= out_ovf_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign result_index_o = out_index_q;
  assign status_o       = out_status_q;
  assign overflow_o     = out_ovf_q;
  assign last_of_run_o  = out_last_q;

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == luds_pkg::ST_F_DIV_W || state_q == luds_pkg::ST_S_BK_DW))
    else $error("divider finished while sequencer was not waiting");

  a_solve_needs_factor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == luds_pkg::ST_S_PERM_A) |-> factor_valid_q)
    else $error("solve started without a valid factor");

  a_rhs_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == luds_pkg::ST_IDLE) |-> (rhs_cnt_q < m_eff))
    else $error("rhs count out of range");

  a_load_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == luds_pkg::ST_IDLE) |-> (ld_row_q < m_eff && ld_col_q < m_eff))
    else $error("matrix load position out of range");

endmodule

@@ dv/tb_lu_decompose_solve_unit.sv @@
// Self-checking testbench for lu_decompose_solve_unit with a built-in LU solver predictor.
`timescale 1ns / 100ps

class lu_solve_board;
  typedef struct {
    logic [31:0] value;
    logic [3:0]  index;
    logic [1:0]  status;
    logic        ovf;
    logic        last;
  } result_t;

  result_t        expected_q[$];
  int             errors;
  int             results_seen;
  int             elements_noted;
  logic [4:0]     dim_reg;
  logic [30:0]    thr_reg;
  int             mat[16][16];
  int             rhs[16];
  int             perm[16];
  int             mat_cnt;
  int             rhs_cnt;
  bit             factor_ok;
  bit             sat_flag;

  function void reset_state();
    expected_q.delete();
    for (int i = 0; i < 16; i++) begin
      perm[i] = i;
      rhs[i] = 0;
      for (int j = 0; j < 16; j++) mat[i][j] = 0;
    end
    mat_cnt = 0;
    rhs_cnt = 0;
    factor_ok = 0;
    dim_reg = luds_pkg::DIM_RESET;
    thr_reg = luds_pkg::THR_RESET;
  endfunction

  function void write_reg(logic idx, logic [31:0] data);
    if (idx == luds_pkg::REG_DIMENSION) begin
      dim_reg = data[4:0];
      mat_cnt = 0;
      rhs_cnt = 0;
      factor_ok = 0;
    end else begin
      thr_reg = data[30:0];
    end
  endfunction

  function int order();
    if (dim_reg == 0) return 1;
    if (dim_reg > 16) return 16;
    return dim_reg;
  endfunction

  function int sat32(longint v);
    if (v > 64'sh7fff_ffff) begin
      sat_flag = 1;
      return 32'sh7fff_ffff;
    end
    if (v < -64'sh8000_0000) begin
      sat_flag = 1;
      return 32'sh8000_0000;
    end
    return int'(v);
  endfunction

  function longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    if (p >= 0) return p >>> 16;
    return -((-p + 65535) >>> 16);
  endfunction

  function int qdiv(longint a, longint b);
    if (b == 0) begin
      sat_flag = 1;
      return (a < 0) ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return sat32((a * 65536) / b);
  endfunction

  function longint magn(int v);
    longint x;
    x = v;
    return (x < 0) ? -x : x;
  endfunction

  function bit factorize(int m);
    int     best;
    longint bestv;
    longint v;
    int     t;
    int     f;
    for (int c = 0; c < m; c++) perm[c] = c;
    for (int c = 0; c < m; c++) begin
      best = c;
      bestv = magn(mat[c][c]);
      for (int r = c + 1; r < m; r++) begin
        v = magn(mat[r][c]);
        if (v > bestv) begin
          bestv = v;
          best = r;
        end
      end
      if (bestv == 0 || bestv < longint'(thr_reg)) return 0;
      if (best != c) begin
        for (int k = 0; k < m; k++) begin
          t = mat[c][k];
          mat[c][k] = mat[best][k];
          mat[best][k] = t;
        end
        t = perm[c];
        perm[c] = perm[best];
        perm[best] = t;
      end
      for (int r = c + 1; r < m; r++) begin
        f = qdiv(mat[r][c], mat[c][c]);
        mat[r][c] = f;
        for (int k = c + 1; k < m; k++)
          mat[r][k] = sat32(longint'(mat[r][k]) - qmul(f, mat[c][k]));
      end
    end
    return 1;
  endfunction

  function void push(int val, int idx, logic [1:0] st, bit ovf, bit last);
    result_t e;
    e.value = val;
    e.index = idx[3:0];
    e.status = st;
    e.ovf = ovf;
    e.last = last;
    expected_q.insert(expected_q.size(), e);
  endfunction

  function void note_element(logic op, logic [31:0] raw);
    int m;
    int n;
    int y[16];
    bit ok;
    m = order();
    elements_noted++;
    if (op == luds_pkg::OP_MATRIX) begin
      factor_ok = 0;
      n = mat_cnt;
      if (n >= m * m) n = 0;
      mat[n / m][n % m] = int'(raw);
      n++;
      if (n < m * m) begin
        mat_cnt = n;
        return;
      end
      mat_cnt = 0;
      sat_flag = 0;
      ok = factorize(m);
      factor_ok = ok;
      push(0, 0, ok ? luds_pkg::STATUS_OK : luds_pkg::STATUS_SINGULAR, sat_flag, 1);
    end else begin
      if (!factor_ok) begin
        rhs_cnt = 0;
        push(0, 0, luds_pkg::STATUS_REFUSED, 0, 1);
        return;
      end
      n = rhs_cnt;
      if (n >= m) n = 0;
      rhs[n] = int'(raw);
      n++;
      if (n < m) begin
        rhs_cnt = n;
        return;
      end
      rhs_cnt = 0;
      sat_flag = 0;
      for (int i = 0; i < m; i++) y[i] = rhs[perm[i] % 16];
      for (int i = 0; i < m; i++)
        for (int k = 0; k < i; k++)
          y[i] = sat32(longint'(y[i]) - qmul(mat[i][k], y[k]));
      for (int i = m - 1; i >= 0; i--) begin
        for (int k = i + 1; k < m; k++)
          y[i] = sat32(longint'(y[i]) - qmul(mat[i][k], y[k]));
        y[i] = qdiv(y[i], mat[i][i]);
      end
      for (int i = 0; i < m; i++)
        push(y[i], i, luds_pkg::STATUS_SOLUTION, sat_flag, i == m - 1);
    end
  endfunction

  function void check_result(logic [31:0] val, logic [3:0] idx, logic [1:0] st,
                             logic ovf, logic last);
    result_t e;
    results_seen++;
    if (expected_q.size() == 0) begin
      $error("unexpected result value=%h status=%0d", val, st);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (val !== e.value) begin
      $error("result_value exp=%h act=%h", e.value, val);
      errors++;
    end
    if (idx !== e.index) begin
      $error("result_index exp=%0d act=%0d", e.index, idx);
      errors++;
    end
    if (st !== e.status) begin
      $error("status exp=%0d act=%0d", e.status, st);
      errors++;
    end
    if (ovf !== e.ovf) begin
      $error("overflow exp=%0d act=%0d", e.ovf, ovf);
      errors++;
    end
    if (last !== e.last) begin
      $error("last_of_run exp=%0d act=%0d", e.last, last);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_lu_decompose_solve_unit;

  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        opcode_i;
  logic [31:0] element_value_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] result_value_o;
  logic [3:0]  result_index_o;
  logic [1:0]  status_o;
  logic        overflow_o;
  logic        last_of_run_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lu_solve_board board;
  int          cycles;
  bit          calm;
  int          stall_left;
  int          phases;

  lu_decompose_solve_unit dut (.*);

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    board = new();
    board.reset_state();
    rst_ni = 0;
    in_valid_i = 0;
    opcode_i = luds_pkg::OP_MATRIX;
    element_value_i = '0;
    out_stall_i = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        board.check_result(result_value_o, result_index_o, status_o, overflow_o,
                           last_of_run_o);
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1;
      end else if (calm || $urandom_range(0, 99) < 70) begin
        out_stall_i <= 0;
      end else begin
        out_stall_i <= 1;
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(0, 2);
      end
    end
  end

  initial cycles = 0;
  initial stall_left = 0;

  task automatic send_element(logic op, logic [31:0] val);
    int gap;
    gap = 0;
    if (!calm) begin
      if ($urandom_range(0, 9) == 0) gap = $urandom_range(5, 40);
      else if ($urandom_range(0, 9) < 4) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    opcode_i <= op;
    element_value_i <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_element(op, val);
  endtask

  task automatic drain(int settle);
    in_valid_i <= 0;
    while (board.pending() > 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    board.write_reg(idx, data);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic configure(logic [4:0] dim, logic [30:0] thr);
    drain(64);
    write_reg(luds_pkg::REG_DIMENSION, {27'd0, dim});
    write_reg(luds_pkg::REG_THRESHOLD, {1'b0, thr});
    phases++;
  endtask

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 32'h3ffff) - 32'h20000;
    if (r < 80) return 32'h0;
    if (r < 85) return 32'h7fff_ffff;
    if (r < 90) return 32'h8000_0000;
    return $urandom();
  endfunction

  task automatic random_phase(bit forced_pause);
    logic [4:0]  dim;
    logic [30:0] thr;
    int          r;
    int          m;
    int          groups;
    r = $urandom_range(0, 99);
    if (r < 70) dim = 5'($urandom_range(1, 4));
    else if (r < 86) dim = 5'($urandom_range(5, 8));
    else if (r < 92) dim = 5'($urandom_range(9, 16));
    else if (r < 97) dim = 0;
    else dim = 5'($urandom_range(17, 31));
    r = $urandom_range(0, 99);
    if (r < 25) thr = 0;
    else if (r < 45) thr = 1;
    else if (r < 80) thr = 31'($urandom_range(0, 32'h20000));
    else if (r < 90) thr = 31'h7fff_ffff;
    else thr = 31'($urandom());
    calm = ($urandom_range(0, 4) == 0);
    configure(dim, thr);
    m = board.order();
    if ($urandom_range(0, 6) == 0) send_element(luds_pkg::OP_RHS, pick_value());
    for (int i = 0; i < m * m; i++) send_element(luds_pkg::OP_MATRIX, pick_value());
    if (forced_pause || $urandom_range(0, 4) == 0) drain(0);
    groups = $urandom_range(1, 4);
    for (int g = 0; g < groups; g++) begin
      if ($urandom_range(0, 9) == 0 && m > 1)
        for (int i = 0; i < $urandom_range(1, m - 1); i++)
          send_element(luds_pkg::OP_RHS, pick_value());
      for (int i = 0; i < m; i++) send_element(luds_pkg::OP_RHS, pick_value());
    end
    if ($urandom_range(0, 9) == 0) send_element(luds_pkg::OP_MATRIX, pick_value());
  endtask

  initial begin
    phases = 0;
    calm = 0;
    @(posedge rst_ni);
    @(posedge clk_i);

    send_element(luds_pkg::OP_RHS, 32'h7fff_ffff);
    configure(5'd1, 31'd0);
    send_element(luds_pkg::OP_MATRIX, 32'h0);
    send_element(luds_pkg::OP_MATRIX, 32'h8000_0000);
    send_element(luds_pkg::OP_RHS, 32'h8000_0000);
    send_element(luds_pkg::OP_RHS, 32'h7fff_ffff);
    configure(5'd1, 31'h7fff_ffff);
    send_element(luds_pkg::OP_MATRIX, Q_ONE);
    send_element(luds_pkg::OP_RHS, Q_ONE);
    configure(5'd0, 31'd1);
    send_element(luds_pkg::OP_MATRIX, 32'h1);
    send_element(luds_pkg::OP_RHS, 32'h7fff_ffff);
    configure(5'd2, 31'd1);
    send_element(luds_pkg::OP_MATRIX, 32'h0);
    send_element(luds_pkg::OP_MATRIX, Q_ONE);
    send_element(luds_pkg::OP_MATRIX, Q_ONE);
    send_element(luds_pkg::OP_MATRIX, 32'h0);
    send_element(luds_pkg::OP_RHS, Q_ONE);
    send_element(luds_pkg::OP_RHS, 32'h0002_0000);
    send_element(luds_pkg::OP_MATRIX, Q_ONE);
    send_element(luds_pkg::OP_MATRIX, 32'h0002_0000);
    send_element(luds_pkg::OP_MATRIX, -Q_ONE);
    send_element(luds_pkg::OP_MATRIX, Q_ONE);
    send_element(luds_pkg::OP_RHS, 32'h0);
    send_element(luds_pkg::OP_RHS, Q_ONE);

    random_phase(1);
    while (board.elements_noted < 480) random_phase(0);

    drain(200);
    $display("covered %0d elements over %0d register settings, %0d results checked",
             board.elements_noted, phases, board.results_seen);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
